@@ sv/bws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bws_pkg: shared constants for the bilinear window sampler
// Window geometry, default arithmetic widths and cell addressing helpers.
// ----------------------------------------------------------------------------
package bws_pkg;

    // Window geometry: cells are addressed column * WINDOW_WIDTH + row.
    localparam int WINDOW_WIDTH = 3;
    localparam int CELL_COUNT   = WINDOW_WIDTH * WINDOW_WIDTH;
    localparam int CELL_IDX_W   = 4;

    // Default sample and fraction widths.
    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Input beat kinds carried on the slave-side tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Offset of the cell used in each of the first four blend steps:
    // left-lower, right-lower, left-upper, right-upper relative to the base cell.
    function automatic logic [CELL_IDX_W-1:0] step_offset(input logic [1:0] step);
        logic [CELL_IDX_W-1:0] off;
        begin
            case (step)
                2'd0:    off = CELL_IDX_W'(0);
                2'd1:    off = CELL_IDX_W'(WINDOW_WIDTH);
                2'd2:    off = CELL_IDX_W'(1);
                default: off = CELL_IDX_W'(WINDOW_WIDTH + 1);
            endcase
            return off;
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/bilinear_window_sampler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_window_sampler_core: 3x3 window store with bilinear sampling
// Load beats fill window cells; sample beats blend four cells with one
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one cell of the 3x3 window and produces no
// output beat; loads to a cell index above 8 are dropped. A sample beat
// (tuser = 1) goes from acceptance to the output register through a check
// state that tests the valid marks of the four chosen cells, six steps on
// the single shared multiplier (two products per row blend, two for the
// column blend), and a rounding state. The input side is not ready while a
// sample is in flight, so a new beat is taken only after the sample has
// left the rounding state; while idle, loads run at one per cycle. A sample
// that finds an invalid cell skips the multiplier and goes from the check
// state straight to the rounding state. While the output register holds a
// beat that has not been taken, a finished sample waits in the rounding
// state. An output beat carries the rounded blend on tdata and the
// all-cells-valid flag on tuser; the value is zero when the flag is low.
// All window cells are invalid after reset.
module bilinear_window_sampler_core
    import bws_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_BITS     = CELL_IDX_W + VALUE_BITS + 1 + 2 * FRAC_BITS,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: cell_index, cell_value, cell_valid, frac_x, frac_y, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode
    input  wire logic                   s_axis_tuser,
    // Output stream.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata from bit 0: sample_value, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: sample_ok
    output logic                        m_axis_tuser
);

    localparam int W_W   = FRAC_BITS + 1;
    localparam int OPA_W = VALUE_BITS + FRAC_BITS;
    localparam int PRD_W = OPA_W + W_W;
    localparam int ACC_W = VALUE_BITS + 2 * FRAC_BITS;

    localparam logic [W_W-1:0]   FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W_W-1:0]   FRAC_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'({1'b1, {(2 * FRAC_BITS - 1){1'b0}}});
    localparam logic [2:0]       STEP_LAST = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ROUND
    } state_t;

    // Field extraction from the input beat.
    logic [CELL_IDX_W-1:0] in_index;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_valid_mark;
    logic [FRAC_BITS-1:0]  in_frac_x;
    logic [FRAC_BITS-1:0]  in_frac_y;

    assign in_index      = s_axis_tdata[CELL_IDX_W-1:0];
    assign in_value      = s_axis_tdata[CELL_IDX_W +: VALUE_BITS];
    assign in_valid_mark = s_axis_tdata[CELL_IDX_W + VALUE_BITS];
    assign in_frac_x     = s_axis_tdata[CELL_IDX_W + VALUE_BITS + 1 +: FRAC_BITS];
    assign in_frac_y     = s_axis_tdata[CELL_IDX_W + VALUE_BITS + 1 + FRAC_BITS +: FRAC_BITS];

    // Window storage; values of invalid cells are never used, so only the marks reset.
    logic [VALUE_BITS-1:0] window_reg [CELL_COUNT];
    logic [CELL_COUNT-1:0] valid_reg;

    state_t                state_reg;
    logic [2:0]            step_reg;
    logic [CELL_IDX_W-1:0] base_reg;
    logic [W_W-1:0]        wx_reg;
    logic [W_W-1:0]        wy_reg;
    logic                  ok_reg;
    logic [OPA_W-1:0]      r0_reg;
    logic [OPA_W-1:0]      r1_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_ok_reg;

    logic in_fire;
    logic out_free;
    logic out_load;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == S_ROUND) && out_free;

    // Per-axis selection of neighbor pair and weight.
    logic [W_W-1:0]        fx_ext;
    logic [W_W-1:0]        fy_ext;
    logic                  sx;
    logic                  sy;
    logic [W_W-1:0]        wx_next;
    logic [W_W-1:0]        wy_next;
    logic [CELL_IDX_W-1:0] base_next;

    assign fx_ext    = {1'b0, in_frac_x};
    assign fy_ext    = {1'b0, in_frac_y};
    assign sx        = fx_ext > FRAC_HALF;
    assign sy        = fy_ext > FRAC_HALF;
    assign wx_next   = sx ? (fx_ext - FRAC_HALF) : (fx_ext + FRAC_HALF);
    assign wy_next   = sy ? (fy_ext - FRAC_HALF) : (fy_ext + FRAC_HALF);
    assign base_next = (sx ? CELL_IDX_W'(WINDOW_WIDTH) : CELL_IDX_W'(0))
                     + CELL_IDX_W'(sy);

    // Valid check of the four chosen cells.
    logic cells_ok;

    assign cells_ok = valid_reg[base_reg]
                   && valid_reg[base_reg + CELL_IDX_W'(WINDOW_WIDTH)]
                   && valid_reg[base_reg + CELL_IDX_W'(1)]
                   && valid_reg[base_reg + CELL_IDX_W'(WINDOW_WIDTH + 1)];

    // Operand selection for the shared multiplier.
    logic [CELL_IDX_W-1:0] rd_addr;
    logic [VALUE_BITS-1:0] rd_value;
    logic [VALUE_BITS-1:0] rd_biased;
    logic [OPA_W-1:0]      op_a;
    logic [W_W-1:0]        w_sel;
    logic [W_W-1:0]        op_b;
    logic [PRD_W-1:0]      prod;
    logic [ACC_W-1:0]      sum;

    assign rd_addr   = base_reg + step_offset(step_reg[1:0]);
    assign rd_value  = window_reg[rd_addr];
    // Adding half the range to a two's complement value flips its sign bit.
    assign rd_biased = {~rd_value[VALUE_BITS-1], rd_value[VALUE_BITS-2:0]};

    always_comb
    begin
        case (step_reg)
            3'd4:    op_a = r0_reg;
            3'd5:    op_a = r1_reg;
            default: op_a = OPA_W'(rd_biased);
        endcase
    end

    assign w_sel = step_reg[2] ? wy_reg : wx_reg;
    assign op_b  = step_reg[0] ? w_sel : (FRAC_ONE - w_sel);
    assign prod  = PRD_W'(op_a) * PRD_W'(op_b);
    // Even steps start a new blend, odd steps finish it.
    assign sum   = (step_reg[0] ? acc_reg : ACC_W'(0)) + prod[ACC_W-1:0];

    // Rounding to nearest, ties upward, then removal of the bias.
    logic [ACC_W-1:0]      rnd;
    logic [VALUE_BITS-1:0] res_biased;
    logic [VALUE_BITS-1:0] res_value;

    assign rnd        = acc_reg + RND_HALF;
    assign res_biased = rnd[ACC_W-1 -: VALUE_BITS];
    assign res_value  = {~res_biased[VALUE_BITS-1], res_biased[VALUE_BITS-2:0]};

    // Window value writes on load beats.
    always_ff @(posedge clk)
    begin
        if (in_fire && (s_axis_tuser == OP_LOAD) && (in_index < CELL_IDX_W'(CELL_COUNT)))
        begin
            window_reg[in_index] <= in_value;
        end
    end

    // Sequencer, valid marks and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            ok_reg        <= 1'b0;
            r0_reg        <= '0;
            r1_reg        <= '0;
            acc_reg       <= '0;
            out_value_reg <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            // The output beat is set when a result is loaded and cleared when taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == OP_LOAD)
                        begin
                            if (in_index < CELL_IDX_W'(CELL_COUNT))
                            begin
                                valid_reg[in_index] <= in_valid_mark;
                            end
                        end
                        else
                        begin
                            base_reg  <= base_next;
                            wx_reg    <= wx_next;
                            wy_reg    <= wy_next;
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    ok_reg    <= cells_ok;
                    acc_reg   <= '0;
                    step_reg  <= 3'd0;
                    state_reg <= cells_ok ? S_MUL : S_ROUND;
                end

                S_MUL:
                begin
                    acc_reg <= sum;
                    if (step_reg == 3'd1)
                    begin
                        r0_reg <= sum[OPA_W-1:0];
                    end
                    if (step_reg == 3'd3)
                    begin
                        r1_reg <= sum[OPA_W-1:0];
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end

                S_ROUND:
                begin
                    if (out_free)
                    begin
                        out_ok_reg    <= ok_reg;
                        out_value_reg <= ok_reg ? res_value : '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_value_reg);
    assign m_axis_tuser  = out_ok_reg;

endmodule
`default_nettype wire

@@ tb/sv/tb_bilinear_window_sampler_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_window_sampler_core: self-checking bench for the window sampler
// Walks a short directed table, then random load/sample sequences, with bursty
// input, a stalling output side and one long output hold-off. Every output beat
// is checked against an in-bench bilinear predictor, or a typed row's expectation.
// ----------------------------------------------------------------------------
module tb_bilinear_window_sampler_core;
    import bws_pkg::*;

    localparam int IN_W        = 40;
    localparam int OUT_W       = 16;
    localparam int FRAC_ONE    = 256;
    localparam int FRAC_HALF   = 128;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT = 3000;
    localparam int ROW_COUNT   = 25;

    // One input beat plus an optional hand-written expectation.
    typedef struct {
        logic        op;
        logic [3:0]  idx;
        logic [15:0] value;
        logic        valid;
        logic [7:0]  fx;
        logic [7:0]  fy;
        bit          typed;
        logic [15:0] want_value;
        logic        want_ok;
    } stim_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = OP_LOAD;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    // Predictor state: the window as the block should hold it.
    logic [15:0] win_value [CELL_COUNT];
    bit          win_valid [CELL_COUNT];

    // Expected output beats, {sample_ok, sample_value}, oldest first.
    logic [16:0] pending_samples [$];

    stim_row_t directed_rows [ROW_COUNT];

    int error_count   = 0;
    int fed_count     = 0;
    int load_count    = 0;
    int dropped_count = 0;
    int sample_count  = 0;
    int checked_count = 0;
    int ok_count      = 0;
    int stall_cycles  = 0;
    bit hold_done     = 1'b0;

    bilinear_window_sampler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Choose the neighbour pair and its weight for one axis.
    task automatic axis_pick(input logic [7:0] frac, output int shift, output int weight);
        if (frac > FRAC_HALF)
        begin
            shift  = 1;
            weight = frac - FRAC_HALF;
        end
        else
        begin
            shift  = 0;
            weight = frac + FRAC_HALF;
        end
    endtask

    // Bilinear blend over the predicted window, rounded half up.
    task automatic blend_window(input logic [7:0] fx, input logic [7:0] fy,
                                output logic [15:0] value, output logic ok);
        int              sx, sy, wx, wy, base;
        longint unsigned c00, c10, c01, c11, r0, r1, acc;
        logic [15:0]     res;
        axis_pick(fx, sx, wx);
        axis_pick(fy, sy, wy);
        base = sx * WINDOW_WIDTH + sy;
        ok = win_valid[base] && win_valid[base + WINDOW_WIDTH] &&
             win_valid[base + 1] && win_valid[base + WINDOW_WIDTH + 1];
        if (!ok)
        begin
            value = '0;
        end
        else
        begin
            // Offset by half range so the blend works on unsigned values.
            c00 = longint'(win_value[base] ^ 16'h8000);
            c10 = longint'(win_value[base + WINDOW_WIDTH] ^ 16'h8000);
            c01 = longint'(win_value[base + 1] ^ 16'h8000);
            c11 = longint'(win_value[base + WINDOW_WIDTH + 1] ^ 16'h8000);
            r0  = (FRAC_ONE - wx) * c00 + wx * c10;
            r1  = (FRAC_ONE - wx) * c01 + wx * c11;
            acc = (FRAC_ONE - wy) * r0 + wy * r1 + (64'd1 << 15);
            res = acc[31:16];
            value = res ^ 16'h8000;
        end
    endtask

    // Update the predictor for one accepted beat.
    task automatic take_beat(input stim_row_t b);
        logic [15:0] value;
        logic        ok;
        fed_count++;
        if (b.op == OP_LOAD)
        begin
            if (b.idx < CELL_COUNT)
            begin
                win_value[b.idx] = b.value;
                win_valid[b.idx] = b.valid;
                load_count++;
            end
            else
            begin
                dropped_count++;
            end
        end
        else
        begin
            sample_count++;
            blend_window(b.fx, b.fy, value, ok);
            if (b.typed)
                pending_samples.push_back({b.want_ok, b.want_value});
            else
                pending_samples.push_back({ok, value});
        end
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic offer_beat(input stim_row_t b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.op;
        s_axis_tdata  <= {3'b000, b.fy, b.fx, b.valid, b.value, b.idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        take_beat(b);
    endtask

    // Drop valid for a number of cycles.
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic stim_row_t stim_row(input logic op, input logic [3:0] idx,
                                           input logic [15:0] value, input logic valid,
                                           input logic [7:0] fx, input logic [7:0] fy,
                                           input bit typed, input logic [15:0] want_value,
                                           input logic want_ok);
        stim_row_t r;
        r.op = op;
        r.idx = idx;
        r.value = value;
        r.valid = valid;
        r.fx = fx;
        r.fy = fy;
        r.typed = typed;
        r.want_value = want_value;
        r.want_ok = want_ok;
        return r;
    endfunction

    // Value for a load: mostly random, sometimes an extreme.
    function automatic logic [15:0] cell_sample_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sub-pixel fraction: mostly random, sometimes an end or at or around the half point.
    function automatic logic [7:0] frac_pick();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd127;
            2: return 8'd128;
            3: return 8'd129;
            4: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Output checker.
    always @(posedge clk)
    begin
        logic [16:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch("unexpected output beat, value", $signed(m_axis_tdata), 0);
            end
            else
            begin
                want = pending_samples.pop_front();
                checked_count++;
                if (m_axis_tuser)
                    ok_count++;
                if (m_axis_tdata !== want[15:0])
                    report_mismatch("sample_value", $signed(m_axis_tdata), $signed(want[15:0]));
                if (m_axis_tuser !== want[16])
                    report_mismatch("sample_ok", m_axis_tuser, want[16]);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_samples.size());
            $display("status: fail");
            $finish;
        end
    end

    // Output side: ready in phases of varying density, plus one long hold-off.
    initial
    begin : rx_pattern
        int phase_len;
        int ready_pct;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && fed_count >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            phase_len = $urandom_range(5, 40);
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
            repeat (phase_len)
            begin
                m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge clk);
            end
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        int        counted;
        int        burst_left;
        int        cell_no;
        int        n;
        stim_row_t b;

        for (int i = 0; i < CELL_COUNT; i++)
        begin
            win_value[i] = '0;
            win_valid[i] = 1'b0;
        end

        // Directed table. Typed rows can be read straight off the rules:
        // an empty window, an invalid cell, or a half/half sample that
        // lands on the centre cell with full weight.
        directed_rows[0]  = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd0, 8'd0,
                                     1'b1, 16'h0000, 1'b0);
        directed_rows[1]  = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd255, 8'd255,
                                     1'b1, 16'h0000, 1'b0);
        directed_rows[2]  = stim_row(OP_LOAD, 4'd9, 16'h7FFF, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[3]  = stim_row(OP_LOAD, 4'd15, 16'h8000, 1'b1, 8'd255, 8'd255,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[4]  = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd128, 8'd128,
                                     1'b1, 16'h0000, 1'b0);
        directed_rows[5]  = stim_row(OP_LOAD, 4'd0, 16'h8000, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[6]  = stim_row(OP_LOAD, 4'd1, 16'h7FFF, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[7]  = stim_row(OP_LOAD, 4'd2, 16'h0001, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[8]  = stim_row(OP_LOAD, 4'd3, 16'hFFFF, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[9]  = stim_row(OP_LOAD, 4'd4, 16'h1234, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[10] = stim_row(OP_LOAD, 4'd5, 16'h8000, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[11] = stim_row(OP_LOAD, 4'd6, 16'h7FFF, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[12] = stim_row(OP_LOAD, 4'd7, 16'h0000, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[13] = stim_row(OP_LOAD, 4'd8, 16'hABCD, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[14] = stim_row(OP_SAMPLE, 4'd15, 16'hFFFF, 1'b1, 8'd128, 8'd128,
                                     1'b1, 16'h1234, 1'b1);
        directed_rows[15] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[16] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd255, 8'd255,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[17] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd129, 8'd129,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[18] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd255, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[19] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd0, 8'd255,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[20] = stim_row(OP_LOAD, 4'd4, 16'h7FFF, 1'b0, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[21] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd64, 8'd64,
                                     1'b1, 16'h0000, 1'b0);
        directed_rows[22] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd200, 8'd200,
                                     1'b1, 16'h0000, 1'b0);
        directed_rows[23] = stim_row(OP_LOAD, 4'd4, 16'h7FFF, 1'b1, 8'd0, 8'd0,
                                     1'b0, 16'h0000, 1'b0);
        directed_rows[24] = stim_row(OP_SAMPLE, 4'd0, 16'h0000, 1'b0, 8'd128, 8'd128,
                                     1'b1, 16'h7FFF, 1'b1);

        // Reset.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROW_COUNT; i++)
            offer_beat(directed_rows[i]);

        // Random part: mostly window fills followed by samples, some noise.
        counted    = 0;
        burst_left = $urandom_range(1, 20);
        while (counted < RANDOM_ITEMS)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            for (int k = 0; k < ((n > 0) ? n : CELL_COUNT + 3); k++)
            begin
                b.typed = 1'b0;
                b.want_value = '0;
                b.want_ok = 1'b0;
                b.fx = 8'($urandom);
                b.fy = 8'($urandom);
                b.value = 16'($urandom);
                b.idx = 4'($urandom);
                b.valid = 1'($urandom);
                if (n > 0)
                begin
                    // Noise: any opcode, any index.
                    b.op = 1'($urandom);
                end
                else if (k < CELL_COUNT)
                begin
                    // Window fill, some cells skipped, a few left invalid.
                    cell_no = k;
                    if ($urandom_range(0, 7) == 0)
                        continue;
                    b.op = OP_LOAD;
                    b.idx = 4'(cell_no);
                    b.value = cell_sample_value();
                    b.valid = ($urandom_range(0, 19) != 0);
                end
                else
                begin
                    // Samples on the filled window; skip some of the extras.
                    if (k > CELL_COUNT && $urandom_range(0, 1) == 0)
                        continue;
                    b.op = OP_SAMPLE;
                    b.fx = frac_pick();
                    b.fy = frac_pick();
                end
                offer_beat(b);
                if (!(b.op == OP_LOAD && b.idx >= CELL_COUNT))
                    counted++;
                burst_left--;
                if (burst_left == 0)
                begin
                    idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
                    burst_left = $urandom_range(1, 20);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain.
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input beats: %0d loads, %0d dropped loads, %0d samples",
                 fed_count, load_count, dropped_count, sample_count);
        $display("checked %0d output beats, %0d with all cells valid, %0d mismatches",
                 checked_count, ok_count, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
